// ----- hdl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int unsigned DepthDefault = 8;
  localparam int unsigned ValueW       = 32;
  localparam int unsigned CountOutW    = 4;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned OutDataW     = 40;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  typedef enum logic [StatusW-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

endpackage

`default_nettype wire

// ----- hdl/spq_ram.sv -----
// ----------------------------------------------------------------------------
// spq_ram
// Simple dual-port storage array, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ram import spq_pkg::*; #(
  parameter int unsigned DEPTH = DepthDefault,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [AW-1:0]            wr_addr_i,
  input  wire logic signed [ValueW-1:0] wr_data_i,
  input  wire logic [AW-1:0]            rd_addr_i,
  output logic signed [ValueW-1:0]      rd_data_o
);

  logic signed [ValueW-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

`default_nettype wire

// ----- hdl/sorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Ascending store of signed values with insert and delete-minimum.
// ----------------------------------------------------------------------------
// Input beats carry the operation in tuser (0 insert, 1 delete smallest) and
// the value in tdata. Every input beat yields exactly one output beat with a
// status, the removed value (zero unless a delete succeeded) and the count
// after the operation.
// Items are handled one at a time; the storage array has a single read and a
// single write port, and entries move one slot per cycle:
//   insert into n entries: written straight into slot 0 when empty, otherwise
//   larger entries shift up one slot from the tail until the value's place,
//   delete from n entries: head read, the rest shift down; full or empty: no move.
// The result sits in an output register; while it waits for the receiver a
// new item is accepted and worked on, and its result holds until the output
// register frees. Reset empties the queue (count to zero); stored entries
// are not cleared and are never used before being written.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue import spq_pkg::*; #(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [ValueW-1:0]   s_axis_tdata_i,   // [31:0] value
  input  wire logic                s_axis_tuser_i,   // [0] mode
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic [OutDataW-1:0]      m_axis_tdata_o    // [1:0] status, [33:2] removed_value,
                                                     // [37:34] count_after, [39:38] zero
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_LAST,
    S_DEL_HEAD,
    S_DEL,
    S_FIN
  } state_e;

  state_e                   state_q, state_d;
  logic [CW-1:0]            count_q, count_d;
  logic [AW-1:0]            idx_q, idx_d;
  logic signed [ValueW-1:0] val_q, val_d;
  status_e                  res_st_q, res_st_d;
  logic signed [ValueW-1:0] res_rem_q, res_rem_d;
  logic                     m_valid_q, m_valid_d;
  logic [OutDataW-1:0]      m_data_q, m_data_d;

  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic signed [ValueW-1:0] wr_data;
  logic [AW-1:0]            rd_addr;
  logic signed [ValueW-1:0] rd_data;
  logic                     in_fire;

  spq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    val_d     = val_q;
    res_st_d  = res_st_q;
    res_rem_d = res_rem_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = val_q;
    rd_addr   = idx_q;

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          val_d     = s_axis_tdata_i;
          res_rem_d = '0;
          res_st_d  = ST_DONE;
          state_d   = S_FIN;
          if (s_axis_tuser_i == MODE_INSERT) begin
            if (count_q == CW'(DEPTH)) begin
              res_st_d = ST_FULL;
            end else begin
              count_d = count_q + 1'b1;
              if (count_q == '0) begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = s_axis_tdata_i;
              end else begin
                rd_addr = AW'(count_q - 1'b1);
                idx_d   = AW'(count_q - 1'b1);
                state_d = S_INS;
              end
            end
          end else begin
            if (count_q == '0) begin
              res_st_d = ST_EMPTY;
            end else begin
              count_d = count_q - 1'b1;
              rd_addr = '0;
              state_d = S_DEL_HEAD;
            end
          end
        end
      end
      S_INS: begin
        wr_en   = 1'b1;
        wr_addr = idx_q + 1'b1;
        if (rd_data >= val_q) begin
          wr_data = rd_data;
          if (idx_q == '0) begin
            state_d = S_INS_LAST;
          end else begin
            rd_addr = idx_q - 1'b1;
            idx_d   = idx_q - 1'b1;
          end
        end else begin
          wr_data = val_q;
          state_d = S_FIN;
        end
      end
      S_INS_LAST: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = val_q;
        state_d = S_FIN;
      end
      S_DEL_HEAD: begin
        res_rem_d = rd_data;
        if (count_q == '0) begin
          state_d = S_FIN;
        end else begin
          rd_addr = AW'(1);
          idx_d   = AW'(1);
          state_d = S_DEL;
        end
      end
      S_DEL: begin
        wr_en   = 1'b1;
        wr_addr = idx_q - 1'b1;
        wr_data = rd_data;
        if (idx_q == AW'(count_q)) begin
          state_d = S_FIN;
        end else begin
          rd_addr = idx_q + 1'b1;
          idx_d   = idx_q + 1'b1;
        end
      end
      S_FIN: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {2'b00, CountOutW'(count_q), res_rem_q, res_st_q};
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    val_q     <= val_d;
    res_st_q  <= res_st_d;
    res_rem_q <= res_rem_d;
    m_data_q  <= m_data_d;
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above capacity");

  a_insert_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && s_axis_tuser_i == MODE_INSERT && count_q != CW'(DEPTH)
    |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not grow the count");

  a_delete_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && s_axis_tuser_i == MODE_DELETE && count_q != '0
    |=> count_q == $past(count_q) - 1'b1)
    else $error("delete did not shrink the count");

  a_write_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (wr_addr < AW'(DEPTH - 1) || wr_addr == AW'(DEPTH - 1)))
    else $error("write outside storage");

  a_result_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN && m_valid_q && !m_axis_tready_i |=> state_q == S_FIN)
    else $error("result dropped while output stalled");

endmodule

`default_nettype wire
